// ===== src/tlfsa_pkg.sv =====
// Shared constants and types for the timed lowest-free-slot allocator.
`default_nettype none
package tlfsa_pkg;

	localparam int SLOTS      = 64;
	localparam int TIME_BITS  = 16;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ROOM_W     = 7;
	localparam int SLOT_NUM_W = 7;
	localparam int FIELD_W    = 16;
	localparam logic [ROOM_W-1:0] ROOM_RESET = ROOM_W'(64);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [SLOTS-1:0]     slot_vec_t;

	// lowest free slot found this cycle
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
		slot_vec_t         onehot;
	} grant_t;

endpackage
`default_nettype wire

// ===== src/tlfsa_lowest_free.sv =====
// Lowest-index priority encoder over the free-slot vector.
`default_nettype none
module tlfsa_lowest_free (
	input  wire tlfsa_pkg::slot_vec_t free_vec,
	output tlfsa_pkg::grant_t         grant
);

	tlfsa_pkg::slot_vec_t lowest;
	logic [tlfsa_pkg::SLOT_W-1:0] idx;

	// isolate lowest set bit
	assign lowest = free_vec & (~free_vec + tlfsa_pkg::slot_vec_t'(1));

	always_comb begin
		idx = '0;
		for (int b = 0; b < tlfsa_pkg::SLOT_W; b++) begin
			for (int i = 0; i < tlfsa_pkg::SLOTS; i++) begin
				if (((i >> b) & 1) == 1) begin
					idx[b] = idx[b] | lowest[i];
				end
			end
		end
	end

	assign grant.found  = |free_vec;
	assign grant.idx    = idx;
	assign grant.onehot = lowest;

endmodule
`default_nettype wire

// ===== src/tlfsa_slot_table.sv =====
// Slot busy bits and release times, with parallel free check and grant update.
`default_nettype none
module tlfsa_slot_table (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 fire,
	input  wire tlfsa_pkg::op_t                 op,
	input  wire tlfsa_pkg::time_t               arrival,
	input  wire tlfsa_pkg::time_t               departure,
	input  wire [tlfsa_pkg::ROOM_W-1:0]         room_count,
	output tlfsa_pkg::grant_t                   grant
);

	tlfsa_pkg::slot_vec_t busy_q;
	tlfsa_pkg::time_t     rel_q [tlfsa_pkg::SLOTS];
	tlfsa_pkg::slot_vec_t busy_left;
	tlfsa_pkg::slot_vec_t usable;
	tlfsa_pkg::slot_vec_t free_vec;

	always_comb begin
		for (int i = 0; i < tlfsa_pkg::SLOTS; i++) begin
			busy_left[i] = busy_q[i] && (rel_q[i] > arrival);
			usable[i]    = int'(room_count) > i;
		end
	end

	assign free_vec = ~busy_left & usable;

	tlfsa_lowest_free u_lowest_free (
		.free_vec (free_vec),
		.grant    (grant)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (fire) begin
			if (op == tlfsa_pkg::OP_CLEAR) begin
				busy_q <= '0;
			end else begin
				busy_q <= busy_left | grant.onehot;
			end
		end
	end

	// release time only matters while the slot is busy
	always_ff @(posedge clk) begin
		if (fire && op == tlfsa_pkg::OP_ALLOC && grant.found) begin
			rel_q[grant.idx] <= departure;
		end
	end

	a_grant_marks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == tlfsa_pkg::OP_ALLOC && grant.found |=> busy_q[$past(grant.idx)])
		else $error("granted slot not marked busy");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == tlfsa_pkg::OP_CLEAR |=> busy_q == '0)
		else $error("clear left a slot busy");

	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		grant.found |-> int'(grant.idx) < int'(room_count))
		else $error("grant beyond room count");

endmodule
`default_nettype wire

// ===== src/timed_lowest_free_slot_allocator.sv =====
// A request word is registered in s1 and its result word in s2, which drives the output.
// Throughput: one request per cycle while the output is not stalled; the parallel release-time
// compare and lowest-free encoder are combinational between the input and result registers.
// Reset (arst_n low): all slots free, pipeline empty, room_count back to 64.
// Output stall backs up through the two registers; the input takes a word while a result waits.
`default_nettype none
module timed_lowest_free_slot_allocator (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [tlfsa_pkg::ROOM_W-1:0]      cfg_data,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              op,
	input  wire [tlfsa_pkg::FIELD_W-1:0]     arrival_time,
	input  wire [tlfsa_pkg::FIELD_W-1:0]     departure_time,
	input  wire [tlfsa_pkg::FIELD_W-1:0]     request_tag,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic                             granted,
	output logic [tlfsa_pkg::SLOT_NUM_W-1:0] slot_number,
	output logic [tlfsa_pkg::FIELD_W-1:0]    result_tag
);

	logic [tlfsa_pkg::ROOM_W-1:0] room_count_q;

	logic                          valid_s1;
	tlfsa_pkg::op_t                op_s1;
	tlfsa_pkg::time_t              arr_s1;
	tlfsa_pkg::time_t              dep_s1;
	logic [tlfsa_pkg::FIELD_W-1:0] tag_s1;

	logic                             valid_s2;
	logic                             granted_s2;
	logic [tlfsa_pkg::SLOT_NUM_W-1:0] slot_s2;
	logic [tlfsa_pkg::FIELD_W-1:0]    tag_s2;

	logic              s2_free;
	logic              s1_adv;
	logic              in_fire;
	tlfsa_pkg::grant_t grant;

	assign cfg_ready = 1'b1;
	assign s2_free   = !valid_s2 || !out_stall;
	assign s1_adv    = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;
	assign in_fire   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= tlfsa_pkg::ROOM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			room_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= tlfsa_pkg::op_t'(op);
			arr_s1 <= tlfsa_pkg::time_t'(arrival_time);
			dep_s1 <= tlfsa_pkg::time_t'(departure_time);
			tag_s1 <= request_tag;
		end
		if (s1_adv) begin
			granted_s2 <= (op_s1 == tlfsa_pkg::OP_ALLOC) && grant.found;
			slot_s2    <= ((op_s1 == tlfsa_pkg::OP_ALLOC) && grant.found)
				? tlfsa_pkg::SLOT_NUM_W'(grant.idx) + tlfsa_pkg::SLOT_NUM_W'(1)
				: '0;
			tag_s2     <= tag_s1;
		end
	end

	tlfsa_slot_table u_slot_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (s1_adv),
		.op         (op_s1),
		.arrival    (arr_s1),
		.departure  (dep_s1),
		.room_count (room_count_q),
		.grant      (grant)
	);

	assign out_valid   = valid_s2;
	assign granted     = granted_s2;
	assign slot_number = slot_s2;
	assign result_tag  = tag_s2;

	a_grant_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> slot_number != '0 && slot_number <= room_count_q)
		else $error("granted word without valid slot");

	a_deny_zero_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> slot_number == '0)
		else $error("denied word with nonzero slot");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1 && $stable(tag_s1))
		else $error("input stage dropped a blocked word");

endmodule
`default_nettype wire

// ===== sim/timed_lowest_free_slot_allocator_test.sv =====
// Self-checking testbench for the timed lowest-free-slot allocator: directed table, then random batches.
`default_nettype none
module timed_lowest_free_slot_allocator_test;
	import tlfsa_pkg::*;

	localparam int RANDOM_WORDS = 1050;
	localparam int HOLD_CYCLES  = 300;
	localparam int TABLE_ROWS   = 21;

	typedef struct packed {
		logic                  granted;
		logic [SLOT_NUM_W-1:0] slot;
		logic [FIELD_W-1:0]    tag;
	} grant_word_t;

	// one directed word; room is written first when new_room is set
	typedef struct packed {
		logic                  new_room;
		logic [ROOM_W-1:0]     room;
		op_t                   op;
		time_t                 arrival;
		time_t                 departure;
		logic [FIELD_W-1:0]    tag;
		logic                  typed;
		logic                  granted;
		logic [SLOT_NUM_W-1:0] slot;
	} table_row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_TOGGLE,
		STALL_HEAVY
	} stall_mode_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  cfg_valid      = 1'b0;
	logic [ROOM_W-1:0]     cfg_data       = '0;
	logic                  in_valid       = 1'b0;
	logic                  op             = OP_ALLOC;
	logic [FIELD_W-1:0]    arrival_time   = '0;
	logic [FIELD_W-1:0]    departure_time = '0;
	logic [FIELD_W-1:0]    request_tag    = '0;
	logic                  out_stall      = 1'b0;
	logic                  cfg_ready;
	logic                  in_stall;
	logic                  out_valid;
	logic                  granted;
	logic [SLOT_NUM_W-1:0] slot_number;
	logic [FIELD_W-1:0]    result_tag;

	timed_lowest_free_slot_allocator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.arrival_time   (arrival_time),
		.departure_time (departure_time),
		.request_tag    (request_tag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted        (granted),
		.slot_number    (slot_number),
		.result_tag     (result_tag)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// allocator shadow state
	logic              slot_taken [SLOTS];
	time_t             slot_free_at [SLOTS];
	logic [ROOM_W-1:0] room_setting;

	grant_word_t pending_grants [$];
	int          errors;
	int          words_sent;
	int          clears_sent;
	int          room_writes;
	int          n_granted;
	int          n_refused;
	int          holds_asked;
	int          burst_left;
	int          gap_max;

	function automatic grant_word_t predict_grant(op_t o, time_t arr, time_t dep,
						      logic [FIELD_W-1:0] t);
		grant_word_t w;
		int          usable;
		w.granted = 1'b0;
		w.slot    = '0;
		w.tag     = t;
		usable    = (int'(room_setting) < SLOTS) ? int'(room_setting) : SLOTS;
		if (o == OP_CLEAR) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_taken[i]   = 1'b0;
				slot_free_at[i] = '0;
			end
		end else begin
			// release pass covers all slots, even those above the room count
			for (int i = 0; i < SLOTS; i++)
				if (slot_taken[i] && slot_free_at[i] <= arr)
					slot_taken[i] = 1'b0;
			for (int i = 0; i < usable; i++) begin
				if (!slot_taken[i]) begin
					slot_taken[i]   = 1'b1;
					slot_free_at[i] = dep;
					w.granted       = 1'b1;
					w.slot          = SLOT_NUM_W'(i + 1);
					break;
				end
			end
		end
		return w;
	endfunction

	task automatic push_request(input op_t o, input time_t arr, input time_t dep,
				    input logic [FIELD_W-1:0] t, input logic typed,
				    input logic g, input logic [SLOT_NUM_W-1:0] s);
		grant_word_t w;
		if (gap_max != 0 && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left != 0)
			burst_left--;
		in_valid       <= 1'b1;
		op             <= o;
		arrival_time   <= arr;
		departure_time <= dep;
		request_tag    <= t;
		do
			@(posedge clk);
		while (in_stall);
		w = predict_grant(o, arr, dep, t);
		if (typed) begin
			w.granted = g;
			w.slot    = s;
		end
		pending_grants.push_back(w);
		words_sent++;
		if (o == OP_CLEAR)
			clears_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_room(input logic [ROOM_W-1:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid    <= 1'b0;
		room_setting  = v;
		room_writes++;
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		grant_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (granted)
				n_granted++;
			else
				n_refused++;
			if (pending_grants.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, granted %0d slot %0d tag %h",
					 $time, granted, slot_number, result_tag);
			end else begin
				w = pending_grants.pop_front();
				if (granted !== w.granted) begin
					errors++;
					$display("%0t: granted expected %0d got %0d (tag %h)",
						 $time, w.granted, granted, w.tag);
				end
				if (slot_number !== w.slot) begin
					errors++;
					$display("%0t: slot_number expected %0d got %0d (tag %h)",
						 $time, w.slot, slot_number, w.tag);
				end
				if (result_tag !== w.tag) begin
					errors++;
					$display("%0t: result_tag expected %h got %h",
						 $time, w.tag, result_tag);
				end
			end
		end
	end

	// output back-pressure: rotating stall patterns plus requested long hold-offs
	stall_mode_t stall_mode;
	int          mode_left;
	int          hold_left;
	int          holds_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode <= STALL_NONE;
			mode_left  <= 0;
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_done != holds_asked) begin
			out_stall  <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				mode_left  <= $urandom_range(8, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE:   out_stall <= 1'b0;
				STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_TOGGLE: out_stall <= ~out_stall;
				default:      out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	initial begin
		#1000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	table_row_t directed_rows [TABLE_ROWS];

	initial begin
		int    phase;
		int    phase_len;
		int    kind;
		int    step_max;
		int    dur_max;
		int    cursor;
		int    dep_int;
		int    room_pick;

		errors       = 0;
		words_sent   = 0;
		clears_sent  = 0;
		room_writes  = 0;
		n_granted    = 0;
		n_refused    = 0;
		holds_asked  = 0;
		burst_left   = 0;
		gap_max      = 3;
		room_setting = ROOM_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			slot_taken[i]   = 1'b0;
			slot_free_at[i] = '0;
		end

		directed_rows = '{
			'{1'b0, 7'd0,   OP_CLEAR, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 7'd0},
			'{1'b0, 7'd0,   OP_ALLOC, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 7'd1},
			'{1'b0, 7'd0,   OP_ALLOC, 16'h0000, 16'd10,   16'h0001, 1'b1, 1'b1, 7'd2},
			// departs before it arrives; slot 2 released at 10 is reused
			'{1'b0, 7'd0,   OP_ALLOC, 16'd10,   16'd5,    16'h0002, 1'b1, 1'b1, 7'd2},
			'{1'b0, 7'd0,   OP_ALLOC, 16'd5,    16'd20,   16'h0003, 1'b1, 1'b1, 7'd2},
			'{1'b0, 7'd0,   OP_ALLOC, 16'hFFFF, 16'hFFFF, 16'h0004, 1'b1, 1'b1, 7'd1},
			'{1'b0, 7'd0,   OP_ALLOC, 16'h0000, 16'h0000, 16'h0005, 1'b0, 1'b0, 7'd0},
			'{1'b0, 7'd0,   OP_CLEAR, 16'h1234, 16'h4321, 16'h8000, 1'b1, 1'b0, 7'd0},
			'{1'b1, 7'd1,   OP_ALLOC, 16'd0,    16'd100,  16'h0006, 1'b1, 1'b1, 7'd1},
			'{1'b0, 7'd0,   OP_ALLOC, 16'd50,   16'd200,  16'h0007, 1'b1, 1'b0, 7'd0},
			'{1'b0, 7'd0,   OP_ALLOC, 16'd100,  16'd0,    16'h0008, 1'b1, 1'b1, 7'd1},
			// zero rooms: nothing ever granted
			'{1'b1, 7'd0,   OP_ALLOC, 16'd0,    16'd0,    16'h0009, 1'b1, 1'b0, 7'd0},
			'{1'b0, 7'd0,   OP_ALLOC, 16'hFFFF, 16'hFFFF, 16'h000A, 1'b1, 1'b0, 7'd0},
			// room count above the slot count is clipped
			'{1'b1, 7'd127, OP_ALLOC, 16'd0,    16'd1000, 16'h000B, 1'b0, 1'b0, 7'd0},
			'{1'b0, 7'd0,   OP_ALLOC, 16'd0,    16'd1000, 16'h000C, 1'b0, 1'b0, 7'd0},
			'{1'b0, 7'd0,   OP_ALLOC, 16'd0,    16'd1000, 16'h000D, 1'b0, 1'b0, 7'd0},
			// shrink to two rooms with slot 3 still busy; it must still be released
			'{1'b1, 7'd2,   OP_ALLOC, 16'd0,    16'd2000, 16'h000E, 1'b0, 1'b0, 7'd0},
			'{1'b0, 7'd0,   OP_ALLOC, 16'd1000, 16'd3000, 16'h000F, 1'b0, 1'b0, 7'd0},
			'{1'b1, 7'd64,  OP_ALLOC, 16'd1000, 16'd3000, 16'h0010, 1'b0, 1'b0, 7'd0},
			'{1'b0, 7'd0,   OP_ALLOC, 16'd1000, 16'd3000, 16'h0011, 1'b0, 1'b0, 7'd0},
			'{1'b0, 7'd0,   OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'h5A5A, 1'b1, 1'b0, 7'd0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].new_room)
				write_room(directed_rows[r].room);
			push_request(directed_rows[r].op, directed_rows[r].arrival,
				     directed_rows[r].departure, directed_rows[r].tag,
				     directed_rows[r].typed, directed_rows[r].granted,
				     directed_rows[r].slot);
		end

		// random batches: mostly ordered requests with random content, some noise
		phase = 0;
		while (words_sent < TABLE_ROWS + RANDOM_WORDS) begin
			room_pick = $urandom_range(0, 15);
			case (room_pick)
				0:       write_room(7'd0);
				1:       write_room(7'd127);
				2:       write_room(7'd64);
				3:       write_room(ROOM_W'($urandom_range(65, 127)));
				4, 5:    write_room(ROOM_W'($urandom_range(17, 63)));
				default: write_room(ROOM_W'($urandom_range(1, 16)));
			endcase
			case ($urandom_range(0, 2))
				0:       step_max = 1;
				1:       step_max = 8;
				default: step_max = 100;
			endcase
			dur_max   = step_max * $urandom_range(1, 40);
			phase_len = $urandom_range(20, 80);
			gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (phase == 2 || phase == 12) begin
				// long output hold-off while words keep coming
				gap_max = 0;
				holds_asked++;
			end
			cursor = $urandom_range(0, 65535);
			push_request(OP_CLEAR, time_t'($urandom), time_t'($urandom),
				     FIELD_W'($urandom), 1'b0, 1'b0, '0);
			repeat (phase_len) begin
				kind = $urandom_range(0, 19);
				if (kind == 0) begin
					cursor = $urandom_range(0, 65535);
					push_request(OP_CLEAR, time_t'($urandom), time_t'($urandom),
						     FIELD_W'($urandom), 1'b0, 1'b0, '0);
				end else if (kind <= 2) begin
					push_request(op_t'($urandom_range(0, 1)), time_t'($urandom),
						     time_t'($urandom), FIELD_W'($urandom),
						     1'b0, 1'b0, '0);
				end else begin
					cursor = cursor + $urandom_range(0, step_max);
					if (cursor > 65535) begin
						cursor = $urandom_range(0, 1000);
						push_request(OP_CLEAR, time_t'($urandom),
							     time_t'($urandom), FIELD_W'($urandom),
							     1'b0, 1'b0, '0);
					end
					dep_int = cursor + $urandom_range(0, dur_max);
					if (dep_int > 65535)
						dep_int = 65535;
					push_request(OP_ALLOC, time_t'(cursor), time_t'(dep_int),
						     FIELD_W'($urandom), 1'b0, 1'b0, '0);
				end
			end
			phase++;
		end

		drain_results();
		repeat (10) @(posedge clk);

		$display("Covered %0d request words (%0d clears) over %0d room_count settings,",
			 words_sent, clears_sent, room_writes);
		$display("with %0d grants, %0d refusals and %0d long output hold-offs.",
			 n_granted, n_refused, holds_asked);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
